@@ src/ett_pkg.sv @@
`timescale 1ns / 1ps

package ett_pkg;

  localparam int unsigned TicksPerSecond = 1000000;
  localparam int unsigned Div1Steps = 32;
  localparam int unsigned Div2Steps = 31;
  localparam logic [31:0] UOne = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_BASE_DURATION = 2'd0,
    REG_MIN_VELOCITY  = 2'd1,
    REG_EASE_MODE     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] from_value;
    logic signed [31:0] to_value;
    logic [63:0]        start_time;
    logic [63:0]        now_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               settled;
  } out_item_t;

  typedef struct packed {
    logic [31:0] from_value;
    logic        up;
    logic [31:0] len;
    logic [63:0] elapsed;
    logic [51:0] need;
    logic [63:0] floor_prod;
    logic        slow;
    logic [31:0] dur;
    logic        settled;
    logic [32:0] rem;
    logic [31:0] quo;
    logic        lower;
    logic [61:0] sq;
    logic [31:0] ease;
    logic [63:0] prod;
  } pipe_t;

endpackage

@@ src/ett_div_step.sv @@
`timescale 1ns / 1ps

module ett_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ett_pkg::pipe_t    pipe_i,
  input  logic              bit_i,
  input  logic [31:0]       divisor_i,
  output logic              valid_o,
  output ett_pkg::pipe_t    pipe_o
);

  logic [32:0]    trial;
  logic           fits;
  ett_pkg::pipe_t pipe_d;
  ett_pkg::pipe_t pipe_q;
  logic           valid_q;

  always_comb begin
    trial = {pipe_i.rem[31:0], bit_i};
    fits = trial >= {1'b0, divisor_i};
    pipe_d = pipe_i;
    pipe_d.rem = fits ? (trial - {1'b0, divisor_i}) : trial;
    pipe_d.quo = {pipe_i.quo[30:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o = pipe_q;

endmodule

@@ src/eased_tween_interpolator.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_ready_o   | in_i  (ett_pkg::in_item_t)
// out     | output    | out_valid_o / out_ready_i | out_o (ett_pkg::out_item_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// one item per cycle, except while a held output stalls the pipeline
// two bit-per-stage dividers: 32 stages for the slow duration, 31 for progress
// the whole pipeline advances together whenever the output register is free or taken
// reset clears valid bits and loads register defaults; no clearing pass

module eased_tween_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ett_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ett_pkg::out_item_t  out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  logic [31:0] base_duration_q;
  logic [31:0] min_velocity_q;
  logic        ease_mode_q;

  logic en;

  ett_pkg::pipe_t a_q, b_q, c_q, d_q, e_q, f_q, g_q;
  ett_pkg::pipe_t a_d, b_d, c_d, d_d, e_d, f_d, g_d;
  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, f_v_q, g_v_q, out_v_q;
  ett_pkg::out_item_t out_d, out_q;

  ett_pkg::pipe_t d1_pipe [ett_pkg::Div1Steps+1];
  logic           d1_v    [ett_pkg::Div1Steps+1];
  ett_pkg::pipe_t d2_pipe [ett_pkg::Div2Steps+1];
  logic           d2_v    [ett_pkg::Div2Steps+1];

  logic [32:0] diff;
  logic [30:0] u;
  logic [30:0] t;
  logic [31:0] s;
  logic [31:0] step;

  assign en = !out_v_q || out_ready_i;
  assign in_ready_o = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_o = out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_duration_q <= 32'd300000;
      min_velocity_q <= 32'd65536;
      ease_mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ett_pkg::REG_BASE_DURATION: base_duration_q <= cfg_data_i;
        ett_pkg::REG_MIN_VELOCITY:  min_velocity_q <= cfg_data_i;
        ett_pkg::REG_EASE_MODE:     ease_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    diff = {in_i.to_value[31], in_i.to_value} - {in_i.from_value[31], in_i.from_value};
    a_d = '0;
    a_d.from_value = in_i.from_value;
    a_d.up = !diff[32];
    a_d.len = diff[32] ? 32'(-diff) : diff[31:0];
    a_d.elapsed = in_i.now_time - in_i.start_time;

    // length times tick rate, and the floor product
    b_d = a_q;
    b_d.need = 52'({20'd0, a_q.len} * 52'(ett_pkg::TicksPerSecond));
    b_d.floor_prod = {32'd0, min_velocity_q} * {32'd0, base_duration_q};

    c_d = b_q;
    c_d.slow = {12'd0, b_q.need} < b_q.floor_prod;
    c_d.rem = {13'd0, b_q.need[51:32]};
    c_d.quo = '0;

    d_d = d1_pipe[ett_pkg::Div1Steps];
    d_d.dur = d1_pipe[ett_pkg::Div1Steps].slow ? d1_pipe[ett_pkg::Div1Steps].quo
                                               : base_duration_q;
    d_d.settled = (d_d.dur == 32'd0) ||
                  (d1_pipe[ett_pkg::Div1Steps].elapsed >= {32'd0, d_d.dur});
    d_d.rem = {1'b0, d1_pipe[ett_pkg::Div1Steps].elapsed[31:0]};
    d_d.quo = '0;

    // ease: square of distance to nearest end
    u = d2_pipe[ett_pkg::Div2Steps].quo[30:0];
    e_d = d2_pipe[ett_pkg::Div2Steps];
    e_d.lower = !u[30];
    t = e_d.lower ? u : 31'(ett_pkg::UOne - {1'b0, u});
    e_d.sq = {31'd0, t} * {31'd0, t};

    s = e_q.sq[61:30];
    f_d = e_q;
    if (e_q.settled) begin
      f_d.ease = ett_pkg::UOne;
    end else if (ease_mode_q) begin
      f_d.ease = e_q.lower ? s : (ett_pkg::UOne - s);
    end else begin
      f_d.ease = {1'b0, e_q.quo[30:0]};
    end

    g_d = f_q;
    g_d.prod = {32'd0, f_q.len} * {32'd0, f_q.ease};

    step = g_q.prod[62:31];
    out_d.value = g_q.up ? (g_q.from_value + step) : (g_q.from_value - step);
    out_d.settled = g_q.settled;
  end

  assign d1_pipe[0] = c_q;
  assign d1_v[0] = c_v_q;
  assign d2_pipe[0] = d_q;
  assign d2_v[0] = d_v_q;

  for (genvar k = 0; k < ett_pkg::Div1Steps; k++) begin : g_div1
    ett_div_step u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (d1_v[k]),
      .pipe_i    (d1_pipe[k]),
      .bit_i     (d1_pipe[k].need[ett_pkg::Div1Steps-1-k]),
      .divisor_i (min_velocity_q),
      .valid_o   (d1_v[k+1]),
      .pipe_o    (d1_pipe[k+1])
    );
  end

  for (genvar k = 0; k < ett_pkg::Div2Steps; k++) begin : g_div2
    ett_div_step u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (d2_v[k]),
      .pipe_i    (d2_pipe[k]),
      .bit_i     (1'b0),
      .divisor_i (d2_pipe[k].dur),
      .valid_o   (d2_v[k+1]),
      .pipe_o    (d2_pipe[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= d1_v[ett_pkg::Div1Steps];
      e_v_q <= d2_v[ett_pkg::Div2Steps];
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
      out_v_q <= g_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
      e_q <= e_d;
      f_q <= f_d;
      g_q <= g_d;
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> in_ready_o) else $error("input stalled with empty output");

  a_slow_shorter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_v_q && d_q.slow) |-> (d_q.dur < base_duration_q))
    else $error("slow length not below base duration");

  a_ease_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_v_q |-> (f_q.ease <= ett_pkg::UOne)) else $error("eased progress above one");

  a_settled_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_v_q && f_q.settled) |-> (f_q.ease == ett_pkg::UOne))
    else $error("settled item not at full progress");
`endif

endmodule
